### src/rsc_pkg.sv
// Package for the reverse-Polish stack calculator.
// Holds token and status codes, default depth and the controller command type.
// No dependencies.
package rsc_pkg;

  // Default stack depth in entries.
  localparam int DEPTH_DEF = 16;

  // Field widths fixed by the token and result formats.
  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Packed widths of the stream data words.
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Token modes.
  localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP  = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic              load;  // request taken: latch operand, read second entry
    logic              exec;  // apply the token to the stack, load the result
    logic [MODE_W-1:0] op;    // token mode being applied
  } cmd_t;

endpackage

### src/rsc_ctrl.sv
// Controller for the reverse-Polish stack calculator.
// Sequences take, execute and deliver for each token; drives the datapath by cmd_t.
// Depends on rsc_pkg.
module rsc_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rsc_pkg::MODE_W-1:0]   in_mode,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output rsc_pkg::cmd_t                cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [rsc_pkg::MODE_W-1:0]   op_r, op_nxt;
  logic                         take;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign take       = in_tvalid && in_tready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_EXEC;
          op_nxt    = in_mode;
        end
      end
      S_EXEC: state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and captured token mode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= rsc_pkg::MODE_PUSH;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  // Commands to the datapath.
  assign cmd.load = take;
  assign cmd.exec = (state_r == S_EXEC);
  assign cmd.op   = op_r;

endmodule

### src/rsc_dp.sv
// Datapath for the reverse-Polish stack calculator.
// Top of stack in a register, lower entries in a memory, ALU and result register.
// Depends on rsc_pkg.
module rsc_dp #(
  parameter int DEPTH = rsc_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rsc_pkg::cmd_t                  cmd,
  input  logic [rsc_pkg::VALUE_W-1:0]    in_operand,
  output logic [rsc_pkg::VALUE_W-1:0]    res_top,
  output logic [rsc_pkg::COUNT_W-1:0]    res_count,
  output logic [rsc_pkg::STATUS_W-1:0]   res_status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = rsc_pkg::VALUE_W;

  // Entries below the top of stack; entry i holds stack position i.
  logic [VW-1:0] mem [DEPTH];

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [VW-1:0]  tos_r, tos_nxt;
  logic [VW-1:0]  opnd_r;
  logic [VW-1:0]  rd_r;
  logic [VW-1:0]  top_r, top_nxt;
  logic [rsc_pkg::STATUS_W-1:0] st_r, st_nxt;
  logic [CW-1:0]  cnt_m1, cnt_m2;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic           wr_en;
  logic           has_one, has_two, not_full;
  logic [VW-1:0]  opa, opb, alu;
  logic [CW+rsc_pkg::COUNT_W-1:0] cnt_ext;

  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign rd_addr  = cnt_m2[AW-1:0];
  assign wr_addr  = cnt_m1[AW-1:0];
  assign has_one  = (cnt_r != '0);
  assign has_two  = (cnt_r >= CW'(2));
  assign not_full = (cnt_r < CW'(DEPTH));

  // Operands: second entry from memory, top from the register, zero if missing.
  assign opb = has_one ? tos_r : '0;
  assign opa = has_two ? rd_r : '0;

  // Arithmetic for the binary operators.
  always_comb begin
    case (cmd.op)
      rsc_pkg::MODE_ADD: alu = opa + opb;
      rsc_pkg::MODE_SUB: alu = opa - opb;
      rsc_pkg::MODE_MUL: alu = opa * opb;
      default:           alu = opa + opb;
    endcase
  end

  // Stack update and result selection for one token.
  always_comb begin
    cnt_nxt = cnt_r;
    tos_nxt = tos_r;
    top_nxt = top_r;
    st_nxt  = st_r;
    wr_en   = 1'b0;
    if (cmd.exec) begin
      case (cmd.op)
        rsc_pkg::MODE_PUSH: begin
          if (not_full) begin
            wr_en   = has_one;
            tos_nxt = opnd_r;
            cnt_nxt = cnt_r + CW'(1);
            top_nxt = opnd_r;
            st_nxt  = rsc_pkg::ST_OK;
          end else begin
            top_nxt = opb;
            st_nxt  = rsc_pkg::ST_OVERFLOW;
          end
        end
        rsc_pkg::MODE_ADD, rsc_pkg::MODE_SUB, rsc_pkg::MODE_MUL: begin
          tos_nxt = alu;
          top_nxt = alu;
          cnt_nxt = has_two ? cnt_m1 : CW'(1);
          st_nxt  = has_two ? rsc_pkg::ST_OK : rsc_pkg::ST_UNDERFLOW;
        end
        rsc_pkg::MODE_POP: begin
          top_nxt = opb;
          if (has_one) begin
            tos_nxt = rd_r;
            cnt_nxt = cnt_m1;
            st_nxt  = rsc_pkg::ST_OK;
          end else begin
            st_nxt  = rsc_pkg::ST_UNDERFLOW;
          end
        end
        default: begin
          top_nxt = opb;
          st_nxt  = rsc_pkg::ST_OK;
        end
      endcase
    end
  end

  // Memory: the old top moves down on a push; second entry read on request.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= tos_r;
    if (cmd.load) rd_r <= mem[rd_addr];
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) opnd_r <= in_operand;
    tos_r <= tos_nxt;
    top_r <= top_nxt;
    st_r  <= st_nxt;
  end

  // Count reported in five bits, zero-extended or truncated.
  assign cnt_ext    = {{rsc_pkg::COUNT_W{1'b0}}, cnt_r};
  assign res_top    = top_r;
  assign res_count  = cnt_ext[rsc_pkg::COUNT_W-1:0];
  assign res_status = st_r;

endmodule

### src/rpn_stack_calculator.sv
// Top level of the reverse-Polish stack calculator.
// Joins the controller (rsc_ctrl) and the datapath (rsc_dp); depends on rsc_pkg.
//
// Usage:
//   Input stream: each request is one decoded token, a mode (push, add,
//   subtract, multiply, pop) and a signed 32-bit operand used by push only.
//   Output stream: exactly one result per token, giving the new top of stack
//   (or the popped value), the entry count after the token, and a status of
//   ok, underflow (a missing operand read as zero) or overflow (push dropped).
//   Timing: a token is taken when in_tvalid and in_tready are both high.
//   The second stack entry is read from the stack memory on that edge, and
//   the token is applied in the next cycle. out_tvalid rises once the
//   controller has passed from its execute state into its output state.
//   One token is in flight at a time: a new token is not taken until the
//   result of the last one has been taken; the controller's take, apply and
//   deliver steps set this.
//   Stalls: the result is held in its register while out_tready is low and
//   in_tready stays low until it is taken.
//   Reset: rst_n (synchronous, active low) empties the stack and the
//   control; stack memory contents are not cleared and need no clearing.
module rpn_stack_calculator #(
  parameter int DEPTH = rsc_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] mode, [34:3] operand_value, [39:35] zero
  input  logic [rsc_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] top_value, [36:32] stack_count, [38:37] status, [39] zero
  output logic [rsc_pkg::OUT_DATA_W-1:0]    out_tdata
);

  rsc_pkg::cmd_t                   cmd;
  logic [rsc_pkg::VALUE_W-1:0]     res_top;
  logic [rsc_pkg::COUNT_W-1:0]     res_count;
  logic [rsc_pkg::STATUS_W-1:0]    res_status;

  rsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (in_tdata[2:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  rsc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_operand (in_tdata[34:3]),
    .res_top    (res_top),
    .res_count  (res_count),
    .res_status (res_status)
  );

  // Pack the result fields, lowest first.
  assign out_tdata = {1'b0, res_status, res_count, res_top};

endmodule
